FILE: design/mru_pkg.sv
// mru_pkg: shared constants and the default probe record for the MRU page
// replacement block. No dependencies; used by mru_cell and mru_page_replacement.
`timescale 1ns / 1ps
`default_nettype none

package mru_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 8;
    localparam int CFG_W         = 4;
    localparam int FAULT_W       = 16;

    localparam int CNT_W_DEF  = $clog2(FRAMES_DEF + 1);
    localparam int SLOT_W_DEF = (FRAMES_DEF > 1) ? $clog2(FRAMES_DEF) : 1;

    // probe record passed cell to cell, default widths
    typedef struct packed {
        logic                     valid;
        logic [PAGE_BITS_DEF-1:0] page;
        logic [PAGE_BITS_DEF-1:0] last;
        logic [CNT_W_DEF-1:0]     n;
        logic [CNT_W_DEF-1:0]     idx;
        logic                     hit;
        logic [SLOT_W_DEF-1:0]    hit_slot;
        logic                     lp_hit;
        logic [SLOT_W_DEF-1:0]    lp_slot;
        logic [PAGE_BITS_DEF-1:0] f0_page;
    } probe_t;

endpackage

`default_nettype wire

FILE: design/mru_cell.sv
// mru_cell: one frame of the MRU block; holds a page and its valid bit and
// updates the probe record handed to its right neighbor. Depends on mru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mru_cell #(
    parameter int  FRAMES       = mru_pkg::FRAMES_DEF,
    parameter int  PAGE_BITS    = mru_pkg::PAGE_BITS_DEF,
    parameter type cell_probe_t = mru_pkg::probe_t
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cell_probe_t          probe_in,
    output cell_probe_t               probe_out,
    input  wire logic                 wr_en,
    input  wire logic [PAGE_BITS-1:0] wr_page
);

    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg;
    cell_probe_t          probe_reg;
    cell_probe_t          probe_next;
    logic                 in_range;
    logic                 match_page;
    logic                 match_last;

    assign in_range   = probe_in.idx < probe_in.n;
    assign match_page = in_range && valid_reg && (page_reg == probe_in.page);
    assign match_last = in_range && valid_reg && (page_reg == probe_in.last);

    always_comb
    begin
        probe_next     = probe_in;
        probe_next.idx = probe_in.idx + CNT_W'(1);
        if (!probe_in.hit && match_page)
        begin
            probe_next.hit      = 1'b1;
            probe_next.hit_slot = probe_in.idx[SLOT_W-1:0];
        end
        if (!probe_in.lp_hit && match_last)
        begin
            probe_next.lp_hit  = 1'b1;
            probe_next.lp_slot = probe_in.idx[SLOT_W-1:0];
        end
        if (probe_in.idx == '0)
        begin
            probe_next.f0_page = page_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            probe_reg <= probe_next;
            if (wr_en)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            page_reg <= wr_page;
        end
    end

    assign probe_out = probe_reg;

endmodule

`default_nettype wire

FILE: design/mru_page_replacement.sv
// mru_page_replacement: top level of the MRU page replacement block; a row of
// mru_cell frames scanned by a probe, plus fill, fault and result logic.
// Depends on mru_pkg and mru_cell.
//
// Usage:
//   Input channel in_valid/in_ready carries one page reference per beat.
//   Output channel out_valid/out_ready carries one result per reference:
//   hit, frame_slot, evicted, evicted_page and the saturating fault_total.
//   cfg_wr_en/cfg_wr_data write frames_in_use (0 acts as 1, above FRAMES
//   acts as FRAMES); write it only while the block is idle.
//   The probe walks one frame cell per cycle, the first at the input beat;
//   the scan result is then registered in end_reg (ST_SCAN to ST_DONE) and
//   committed to the output register in ST_DONE. One reference is in flight
//   at a time, so the next input is taken only after the previous commit.
//   A result waits in the output register while out_ready is low; the next
//   reference is still accepted and scanned, and its commit waits for the
//   output register to drain.
//   Reset clears all frame valid bits, the fill count, the previous page,
//   the fault counter and sets frames_in_use to FRAMES.
`timescale 1ns / 1ps
`default_nettype none

module mru_page_replacement #(
    parameter int FRAMES    = mru_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = mru_pkg::PAGE_BITS_DEF
) (
    input  wire logic                                            clk,
    input  wire logic                                            rst_n,
    input  wire logic                                            cfg_wr_en,
    input  wire logic [mru_pkg::CFG_W-1:0]                       cfg_wr_data,
    input  wire logic                                            in_valid,
    output logic                                                 in_ready,
    input  wire logic [PAGE_BITS-1:0]                            page_number,
    output logic                                                 out_valid,
    input  wire logic                                            out_ready,
    output logic                                                 hit,
    output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0]       frame_slot,
    output logic                                                 evicted,
    output logic [PAGE_BITS-1:0]                                 evicted_page,
    output logic [mru_pkg::FAULT_W-1:0]                          fault_total
);

    import mru_pkg::*;

    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int NW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef struct packed {
        logic                 valid;
        logic [PAGE_BITS-1:0] page;
        logic [PAGE_BITS-1:0] last;
        logic [CNT_W-1:0]     n;
        logic [CNT_W-1:0]     idx;
        logic                 hit;
        logic [SLOT_W-1:0]    hit_slot;
        logic                 lp_hit;
        logic [SLOT_W-1:0]    lp_slot;
        logic [PAGE_BITS-1:0] f0_page;
    } scan_probe_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [CFG_W-1:0]     frames_cfg_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic [CNT_W-1:0]     fill_next;
    logic [PAGE_BITS-1:0] last_page_reg;
    logic [FAULT_W-1:0]   fault_reg;
    logic [FAULT_W-1:0]   fault_next;
    scan_probe_t          end_reg;
    scan_probe_t          chain [FRAMES+1];
    scan_probe_t          inject;
    logic [NW-1:0]        cfg_ext;
    logic [CNT_W-1:0]     n_eff;
    logic                 accept;
    logic                 commit;
    logic                 miss;
    logic                 has_free;
    logic [SLOT_W-1:0]    slot_c;
    logic                 ev_c;
    logic [PAGE_BITS-1:0] ev_page_c;
    logic [FRAMES-1:0]    wr_sel;

    logic                 out_valid_reg;
    logic                 hit_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic                 ev_reg;
    logic [PAGE_BITS-1:0] ev_page_reg;

    // effective frame count
    always_comb
    begin
        cfg_ext = NW'(frames_cfg_reg);
        if (cfg_ext == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (cfg_ext > NW'(FRAMES))
        begin
            n_eff = CNT_W'(FRAMES);
        end
        else
        begin
            n_eff = cfg_ext[CNT_W-1:0];
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign commit   = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        inject       = '0;
        inject.valid = accept;
        inject.page  = page_number;
        inject.last  = last_page_reg;
        inject.n     = n_eff;
    end

    assign chain[0] = inject;

    for (genvar k = 0; k < FRAMES; k++)
    begin : g_cell
        mru_cell #(
            .FRAMES       (FRAMES),
            .PAGE_BITS    (PAGE_BITS),
            .cell_probe_t (scan_probe_t)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .probe_in  (chain[k]),
            .probe_out (chain[k+1]),
            .wr_en     (wr_sel[k]),
            .wr_page   (end_reg.page)
        );
    end

    // resolve the scanned reference
    always_comb
    begin
        miss      = !end_reg.hit;
        has_free  = fill_reg < end_reg.n;
        ev_c      = 1'b0;
        ev_page_c = '0;
        fill_next = fill_reg;
        if (!miss)
        begin
            slot_c = end_reg.hit_slot;
        end
        else if (has_free)
        begin
            slot_c    = fill_reg[SLOT_W-1:0];
            fill_next = fill_reg + CNT_W'(1);
        end
        else
        begin
            // frame 0 is always loaded once frames are full
            ev_c      = 1'b1;
            slot_c    = end_reg.lp_hit ? end_reg.lp_slot : '0;
            ev_page_c = end_reg.lp_hit ? end_reg.last : end_reg.f0_page;
        end
        fault_next = fault_reg;
        if (miss && (fault_reg != '1))
        begin
            fault_next = fault_reg + FAULT_W'(1);
        end
        wr_sel = (commit && miss) ? (FRAMES'(1) << slot_c) : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (chain[FRAMES].valid)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            frames_cfg_reg <= CFG_W'(FRAMES);
            fill_reg       <= '0;
            last_page_reg  <= '0;
            fault_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                frames_cfg_reg <= cfg_wr_data;
            end
            if (commit)
            begin
                fill_reg      <= fill_next;
                last_page_reg <= end_reg.page;
                fault_reg     <= fault_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_SCAN) && chain[FRAMES].valid)
        begin
            end_reg <= chain[FRAMES];
        end
        if (commit)
        begin
            hit_reg     <= !miss;
            slot_reg    <= slot_c;
            ev_reg      <= ev_c;
            ev_page_reg <= ev_page_c;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign frame_slot   = slot_reg;
    assign evicted      = ev_reg;
    assign evicted_page = ev_page_reg;
    assign fault_total  = fault_reg;

`ifndef NO_ASSERTIONS
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && hit_reg |-> !ev_reg)
        else $error("hit result reports an eviction");

    a_fault_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(fault_reg))
        else $error("fault counter moved outside a commit");

    a_scan_end_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain[FRAMES].valid |-> (state_reg == ST_SCAN))
        else $error("probe left the cell row outside the scan state");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(FRAMES))
        else $error("fill count beyond frame count");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_mru_page_replacement.sv
// tb_mru_page_replacement: self-checking bench for the MRU page replacement block.
// A directed table and random reference streams under changing frame counts, each result
// beat checked against an in-bench MRU predictor or a typed table row. Needs mru_pkg and the RTL.
`timescale 1ns / 1ps

module tb_mru_page_replacement;

    import mru_pkg::*;

    localparam int FRAMES      = FRAMES_DEF;
    localparam int PAGE_BITS   = PAGE_BITS_DEF;
    localparam int SLOT_W      = SLOT_W_DEF;
    localparam int LATENCY     = FRAMES + 2;
    localparam int WATCHDOG    = 4000;
    localparam int N_RANDOM    = 1120;
    localparam int MAX_REPORTS = 200;

    typedef logic [PAGE_BITS-1:0] page_t;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               evicted;
        page_t              ev_page;
        logic [FAULT_W-1:0] faults;
    } mru_result_t;

    typedef enum logic {ROW_PAGE, ROW_FRAMES} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        page_t       value;
        logic        typed;
        mru_result_t want;
    } dir_row_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]   cfg_wr_data = '0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    page_t              page_number = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic               hit;
    logic [SLOT_W-1:0]  frame_slot;
    logic               evicted;
    page_t              evicted_page;
    logic [FAULT_W-1:0] fault_total;

    logic        typed_chk  = 1'b0;
    mru_result_t typed_want = '0;
    logic        steady     = 1'b0;
    int          rx_stall   = 0;
    int          quiet_cycles = 0;
    int          mismatches = 0;

    // predictor state
    page_t              res_page [FRAMES]  = '{default: '0};
    logic               res_valid [FRAMES] = '{default: 1'b0};
    int                 fill_level  = 0;
    page_t              prev_page   = '0;
    logic [FAULT_W-1:0] fault_count = '0;
    logic [CFG_W-1:0]   frames_cfg  = CFG_W'(FRAMES);
    mru_result_t        pending_results [$];

    dir_row_t dir_rows [26] = '{
        // page 0 right after reset must fault
        '{ROW_PAGE,   8'd0,   1'b1, '{1'b0, 3'd0, 1'b0, 8'd0,   16'd1}},
        '{ROW_PAGE,   8'd0,   1'b1, '{1'b1, 3'd0, 1'b0, 8'd0,   16'd1}},
        '{ROW_FRAMES, 8'd2,   1'b0, '0},
        '{ROW_PAGE,   8'd255, 1'b1, '{1'b0, 3'd1, 1'b0, 8'd0,   16'd2}},
        '{ROW_PAGE,   8'd1,   1'b1, '{1'b0, 3'd1, 1'b1, 8'd255, 16'd3}},
        // growing resumes the fill
        '{ROW_FRAMES, 8'd8,   1'b0, '0},
        '{ROW_PAGE,   8'd2,   1'b1, '{1'b0, 3'd2, 1'b0, 8'd0,   16'd4}},
        '{ROW_PAGE,   8'd128, 1'b1, '{1'b0, 3'd3, 1'b0, 8'd0,   16'd5}},
        '{ROW_PAGE,   8'd127, 1'b0, '0},
        '{ROW_PAGE,   8'd64,  1'b0, '0},
        '{ROW_PAGE,   8'd85,  1'b0, '0},
        '{ROW_PAGE,   8'd170, 1'b1, '{1'b0, 3'd7, 1'b0, 8'd0,   16'd9}},
        '{ROW_PAGE,   8'd3,   1'b1, '{1'b0, 3'd7, 1'b1, 8'd170, 16'd10}},
        '{ROW_PAGE,   8'd1,   1'b0, '0},
        '{ROW_PAGE,   8'd64,  1'b0, '0},
        // previous page sits above the shrunk count: frame 0 goes
        '{ROW_FRAMES, 8'd2,   1'b0, '0},
        '{ROW_PAGE,   8'd127, 1'b1, '{1'b0, 3'd0, 1'b1, 8'd0,   16'd11}},
        // count above FRAMES, frames 0 and 4 both hold 127
        '{ROW_FRAMES, 8'd15,  1'b0, '0},
        '{ROW_PAGE,   8'd127, 1'b1, '{1'b1, 3'd0, 1'b0, 8'd0,   16'd11}},
        // zero count acts as one frame
        '{ROW_FRAMES, 8'd0,   1'b0, '0},
        '{ROW_PAGE,   8'd9,   1'b1, '{1'b0, 3'd0, 1'b1, 8'd127, 16'd12}},
        '{ROW_PAGE,   8'd9,   1'b0, '0},
        '{ROW_FRAMES, 8'd8,   1'b0, '0},
        '{ROW_PAGE,   8'd255, 1'b1, '{1'b0, 3'd0, 1'b1, 8'd9,   16'd13}},
        '{ROW_PAGE,   8'd255, 1'b1, '{1'b1, 3'd0, 1'b0, 8'd0,   16'd13}},
        '{ROW_PAGE,   8'd0,   1'b1, '{1'b0, 3'd0, 1'b1, 8'd255, 16'd14}}
    };

    mru_page_replacement u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .page_number  (page_number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .frame_slot   (frame_slot),
        .evicted      (evicted),
        .evicted_page (evicted_page),
        .fault_total  (fault_total)
    );

    always #1 clk = ~clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic mru_result_t mru_access(input page_t pg);
        mru_result_t r;
        int          n;
        int          slot;
        int          k;
        bit          found;
        bit          got;
        r = '0;
        n = (frames_cfg == 0) ? 1 : (int'(frames_cfg) > FRAMES) ? FRAMES : int'(frames_cfg);
        found = 1'b0;
        slot = 0;
        for (k = 0; k < n; k++)
        begin
            if (!found && res_valid[k] && res_page[k] == pg)
            begin
                found = 1'b1;
                slot = k;
            end
        end
        if (!found)
        begin
            if (fault_count != '1)
                fault_count++;
            if (fill_level < n)
            begin
                slot = fill_level;
                fill_level++;
            end
            else
            begin
                got = 1'b0;
                slot = 0;
                for (k = 0; k < n; k++)
                begin
                    if (!got && res_valid[k] && res_page[k] == prev_page)
                    begin
                        got = 1'b1;
                        slot = k;
                    end
                end
                if (res_valid[slot])
                begin
                    r.evicted = 1'b1;
                    r.ev_page = res_page[slot];
                end
            end
            res_page[slot] = pg;
            res_valid[slot] = 1'b1;
        end
        prev_page = pg;
        r.hit = found;
        r.slot = SLOT_W'(slot);
        r.faults = fault_count;
        return r;
    endfunction

    // result beats checked before the same-edge input beat is predicted
    always @(posedge clk)
    begin
        mru_result_t want;
        mru_result_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {hit, frame_slot, evicted, evicted_page, fault_total};
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: unexpected result beat",
                                  " hit=%0d slot=%0d ev=%0d page=%0d faults=%0d"},
                                 $time, got.hit, got.slot, got.evicted, got.ev_page,
                                 got.faults);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"%0t: expected hit=%0d slot=%0d ev=%0d page=%0d faults=%0d",
                                      " actual hit=%0d slot=%0d ev=%0d page=%0d faults=%0d"},
                                     $time, want.hit, want.slot, want.evicted, want.ev_page,
                                     want.faults, got.hit, got.slot, got.evicted, got.ev_page,
                                     got.faults);
                    end
                end
            end
            if (cfg_wr_en)
                frames_cfg = cfg_wr_data;
            if (in_valid && in_ready)
            begin
                want = mru_access(page_number);
                if (typed_chk)
                    want = typed_want;
                pending_results.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin
        int gap;
        if (steady)
        begin
            out_ready <= 1'b1;
            rx_stall <= 0;
        end
        else if (rx_stall > 0)
        begin
            out_ready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end
        else
        begin
            gap = idle_len();
            out_ready <= (gap == 0);
            rx_stall <= (gap > 0) ? gap - 1 : 0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG)
        begin
            $display("%0t: no beat for %0d cycles", $time, WATCHDOG);
            $display("mru_page_replacement: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_page(input page_t pg, input logic typed, input mru_result_t want);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        page_number <= pg;
        typed_chk <= typed;
        typed_want <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // drain every expected beat, then write the frame count
    task automatic set_frames(input logic [CFG_W-1:0] count);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= count;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int    sent;
        int    phase;
        int    phase_len;
        int    pick;
        int    k;
        int    pool_size;
        page_t pg;
        page_t last_sent;
        page_t pool [12];

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_FRAMES)
                set_frames(dir_rows[i].value[CFG_W-1:0]);
            else
                send_page(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
        end

        sent = 0;
        last_sent = '0;
        pool_size = 1;
        pool = '{default: '0};
        for (phase = 0; sent < N_RANDOM; phase++)
        begin
            case (phase)
                0: set_frames(CFG_W'(1));
                1: set_frames(CFG_W'(15));
                2: set_frames(CFG_W'(0));
                3: set_frames(CFG_W'(8));
                default: set_frames(CFG_W'($urandom_range(0, 15)));
            endcase
            steady = ($urandom_range(0, 3) == 0);
            pool_size = $urandom_range(2, 12);
            for (k = 0; k < 12; k++)
                pool[k] = page_t'($urandom);
            pick = $urandom_range(0, 2);
            if (pick == 0)
                pool[0] = '0;
            else if (pick == 1)
                pool[0] = '1;
            phase_len = $urandom_range(40, 140);
            repeat (phase_len)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    pg = last_sent;
                else if (pick < 75)
                    pg = pool[$urandom_range(0, pool_size - 1)];
                else
                    pg = page_t'($urandom);
                send_page(pg, 1'b0, '0);
                last_sent = pg;
                sent++;
            end
        end

        steady = 1'b0;
        set_frames(CFG_W'(8));
        repeat (40)
        begin
            pg = ($urandom_range(0, 3) == 0) ? page_t'($urandom)
                                             : pool[$urandom_range(0, pool_size - 1)];
            send_page(pg, 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (mismatches == 0)
            $display("mru_page_replacement: match");
        else
            $display("mru_page_replacement: mismatch");
        $finish;
    end

endmodule
